>>> hdl/nine_bit_symbol_codec_defines.svh
// Assertion macros used by the checker file of the nine-bit symbol codec.
`ifndef NINE_BIT_SYMBOL_CODEC_DEFINES_SVH
`define NINE_BIT_SYMBOL_CODEC_DEFINES_SVH

// Clocked assertion, disabled while reset is held.
`define NBSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define NBSC_NEVER(lbl, cond, msg) \
    `NBSC_ASSERT(lbl, !(cond), msg)

`endif

>>> hdl/nbsc_pkg.sv
// Types, constants and range mapping functions of the nine-bit symbol codec.
package nbsc_pkg;

    localparam int SYM_BITS   = 9;
    localparam int NUM_RANGES = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [15:0] BASE_LATIN1   = 16'h00A1;
    localparam logic [15:0] BASE_PUNCT    = 16'h2010;
    localparam logic [15:0] BASE_CARET    = 16'h005E;
    localparam logic [15:0] BASE_QUESTION = 16'h003F;
    localparam logic [15:0] BASE_GREEK    = 16'h0391;
    localparam logic [15:0] BASE_FULLW    = 16'hFF01;

    // One queue entry: up to two results of one accepted request.
    typedef struct packed {
        logic                enc;
        logic                bad;
        logic                two;
        logic [SYM_BITS-1:0] sym0;
        logic                last0;
        logic [SYM_BITS-1:0] sym1;
        logic                last1;
    } t_cmd;

    typedef struct packed {
        logic                hit;
        logic [SYM_BITS-1:0] val;
    } t_lookup;

    function automatic logic [15:0] range_base(logic [2:0] idx, logic region);
        logic [15:0] b;
        case (idx)
            3'd0:    b = 16'h0020;
            3'd1:    b = 16'h003D;
            3'd2:    b = BASE_QUESTION;
            3'd3:    b = 16'h005C;
            3'd4:    b = BASE_CARET;
            3'd5:    b = BASE_LATIN1;
            3'd6:    b = BASE_PUNCT;
            default: b = region ? BASE_FULLW : BASE_GREEK;
        endcase
        return b;
    endfunction

    function automatic logic [9:0] range_off(logic [2:0] idx);
        logic [9:0] o;
        case (idx)
            3'd0:    o = 10'd0;
            3'd1:    o = 10'd27;
            3'd2:    o = 10'd28;
            3'd3:    o = 10'd56;
            3'd4:    o = 10'd57;
            3'd5:    o = 10'd90;
            3'd6:    o = 10'd313;
            default: o = 10'd479;
        endcase
        return o;
    endfunction

    function automatic logic [9:0] range_end(logic [2:0] idx);
        logic [9:0] e;
        case (idx)
            3'd0:    e = 10'd27;
            3'd1:    e = 10'd28;
            3'd2:    e = 10'd56;
            3'd3:    e = 10'd57;
            3'd4:    e = 10'd90;
            3'd5:    e = 10'd313;
            3'd6:    e = 10'd479;
            default: e = 10'd512;
        endcase
        return e;
    endfunction

    // Map a 9-bit group to its code point: first range whose end lies above it.
    function automatic logic [15:0] val_to_cp(logic [SYM_BITS-1:0] v, logic region);
        logic [15:0] cp;
        logic        found;
        logic [9:0]  dv;
        cp    = BASE_QUESTION;
        found = 1'b0;
        for (int i = 0; i < NUM_RANGES; i++) begin
            dv = {1'b0, v} - range_off(3'(i));
            if (!found && ({1'b0, v} < range_end(3'(i)))) begin
                cp    = range_base(3'(i), region) + {6'd0, dv};
                found = 1'b1;
            end
        end
        return cp;
    endfunction

    // Map a code point back to its 9-bit group; ranges do not overlap.
    function automatic t_lookup cp_to_val(logic [15:0] cp, logic region);
        t_lookup     r;
        logic [15:0] b;
        logic [15:0] d;
        logic [9:0]  sz;
        logic [9:0]  sum;
        r = '0;
        for (int i = 0; i < NUM_RANGES; i++) begin
            b   = range_base(3'(i), region);
            d   = cp - b;
            sz  = range_end(3'(i)) - range_off(3'(i));
            sum = range_off(3'(i)) + {1'b0, d[8:0]};
            if (!r.hit && (cp >= b) && (d < {6'd0, sz})) begin
                r.hit = 1'b1;
                r.val = sum[SYM_BITS-1:0];
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/nbsc_front.sv
// Front end: accepts requests, packs bits and classifies code points into queue entries.
module nbsc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_mode,
    input  logic [15:0]   i_value,
    input  logic          i_last,
    input  logic          i_region,
    input  logic          i_full,
    output logic          o_push,
    output nbsc_pkg::t_cmd o_cmd
);
    import nbsc_pkg::*;

    logic [7:0]  r_acc, n_acc;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_disc, n_disc;

    logic        accept;
    logic        push;
    t_cmd        cmd;

    logic [15:0] e_sum;
    logic [15:0] e_rem;
    logic [4:0]  e_tot;
    logic [4:0]  e_remcnt;
    logic        e_grp;
    logic        e_part;

    t_lookup     lk;
    logic [6:0]  d_acc;
    logic [2:0]  d_cnt;
    logic [15:0] d_sum;
    logic        d_full;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && push;
    assign o_cmd   = cmd;

    // Encode: append the byte above the pending bits.
    assign e_sum    = {8'd0, r_acc} | ({8'd0, i_value[7:0]} << r_cnt);
    assign e_tot    = {1'b0, r_cnt} + 5'd8;
    assign e_grp    = e_tot >= 5'(SYM_BITS);
    assign e_rem    = e_grp ? (e_sum >> SYM_BITS) : e_sum;
    assign e_remcnt = e_grp ? (e_tot - 5'(SYM_BITS)) : e_tot;
    assign e_part   = i_last && (e_remcnt != 5'd0);

    // Decode: a full pending byte is dropped before the group is appended.
    assign lk     = cp_to_val(i_value, i_region);
    assign d_acc  = r_cnt[3] ? 7'd0 : r_acc[6:0];
    assign d_cnt  = r_cnt[3] ? 3'd0 : r_cnt[2:0];
    assign d_sum  = {9'd0, d_acc} | ({7'd0, lk.val} << d_cnt);
    assign d_full = d_cnt == 3'd7;

    always_comb begin
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_disc = r_disc;
        cmd    = '0;
        push   = 1'b0;
        if (i_mode == MODE_ENCODE) begin
            cmd.enc = 1'b1;
            if (e_grp) begin
                cmd.sym0  = e_sum[SYM_BITS-1:0];
                cmd.last0 = i_last && (e_tot == 5'(SYM_BITS));
                if (e_part) begin
                    cmd.two   = 1'b1;
                    cmd.sym1  = e_rem[SYM_BITS-1:0];
                    cmd.last1 = 1'b1;
                end
            end else if (e_part) begin
                cmd.sym0  = e_rem[SYM_BITS-1:0];
                cmd.last0 = 1'b1;
            end
            push = e_grp || e_part;
            if (i_last) begin
                n_acc  = '0;
                n_cnt  = '0;
                n_disc = 1'b0;
            end else begin
                n_acc = e_rem[7:0];
                n_cnt = e_remcnt[3:0];
            end
        end else if (r_disc) begin
            if (i_last) begin
                n_acc  = '0;
                n_cnt  = '0;
                n_disc = 1'b0;
            end
        end else if (!lk.hit) begin
            cmd.bad   = 1'b1;
            cmd.last0 = i_last;
            push      = 1'b1;
            n_acc     = '0;
            n_cnt     = '0;
            n_disc    = !i_last;
        end else begin
            cmd.sym0  = {1'b0, d_sum[7:0]};
            cmd.sym1  = {1'b0, d_sum[15:8]};
            cmd.last1 = i_last;
            cmd.two   = d_full || i_last;
            push      = 1'b1;
            if (i_last || d_full) begin
                n_acc  = '0;
                n_cnt  = '0;
                n_disc = 1'b0;
            end else begin
                n_acc = d_sum[15:8];
                n_cnt = {1'b0, d_cnt} + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_cnt  <= '0;
            r_disc <= 1'b0;
        end else if (accept) begin
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_disc <= n_disc;
        end
    end

endmodule

>>> hdl/nbsc_fifo.sv
// Short queue of result entries between the front and back ends.
module nbsc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nbsc_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output nbsc_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);
    import nbsc_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_count;

    assign o_head  = r_mem[r_rp];
    assign o_empty = r_count == '0;
    assign o_full  = r_count == (FIFO_AW+1)'(FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> hdl/nbsc_back.sv
// Back end: maps queued groups to code points or bytes and drives the output register.
module nbsc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nbsc_pkg::t_cmd i_head,
    input  logic           i_empty,
    input  logic           i_region,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [15:0]    o_value,
    output logic           o_last,
    output logic           o_bad
);
    import nbsc_pkg::*;

    logic                r_valid;
    logic                r_idx;
    logic [15:0]         r_value;
    logic                r_last;
    logic                r_bad;

    logic                load;
    logic [SYM_BITS-1:0] sym;
    logic                sym_last;
    logic [15:0]         value;

    assign load     = !i_empty && (!r_valid || i_ready);
    assign o_pop    = load && (r_idx || !i_head.two);
    assign sym      = r_idx ? i_head.sym1 : i_head.sym0;
    assign sym_last = r_idx ? i_head.last1 : i_head.last0;

    always_comb begin
        if (i_head.bad) begin
            value = '0;
        end else if (i_head.enc) begin
            value = val_to_cp(sym, i_region);
        end else begin
            value = {8'd0, sym[7:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= !o_pop;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value <= value;
            r_last  <= sym_last;
            r_bad   <= i_head.bad;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_last  = r_last;
    assign o_bad   = r_bad;

endmodule

>>> hdl/nine_bit_symbol_codec.sv
// Top level of the nine-bit symbol codec: region register, front end, queue, back end.
// The results of an accepted request enter the queue and then pass through the output register.
// Throughput: one request per cycle; results leave one per cycle while the output is taken, and a
// two-result request sends its results in turn; requests stall while the four-entry queue is full.
// Reset (i_rst_n low, synchronous): clears the bit accumulator, the count, the discard
// flag, the queue and the output valid, and selects the western region range.
module nine_bit_symbol_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Region register write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,    // region_table
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] in_value
    input  logic        s_axis_tuser,   // [0] mode
    input  logic        s_axis_tlast,   // in_last
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_value
    output logic        m_axis_tuser,   // [0] bad_symbol
    output logic        m_axis_tlast    // out_last
);
    import nbsc_pkg::*;

    // Region select: 0 puts Greek on top, 1 the halfwidth/fullwidth forms.
    logic r_region;

    logic push;
    logic pop;
    logic empty;
    logic full;
    t_cmd cmd;
    t_cmd head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= 1'b0;
        end else if (i_cfg_we) begin
            r_region <= i_cfg_wdata;
        end
    end

    // Front end: update the bit accumulator on each request and queue its results.
    nbsc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_mode   (s_axis_tuser),
        .i_value  (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_region (r_region),
        .i_full   (full),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    // Queue: decouple request acceptance from result backpressure.
    nbsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    // Back end: map each group and hold it in the output register until taken.
    nbsc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (empty),
        .i_region (r_region),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_value  (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .o_bad    (m_axis_tuser)
    );

endmodule

>>> hdl/nbsc_checker.sv
// Port-level assertions of the nine-bit symbol codec and their bind.
`include "nine_bit_symbol_codec_defines.svh"

module nbsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // Hold a stalled result unchanged.
    `NBSC_ASSERT(a_out_hold,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast),
        "result changed while stalled")

    // A bad-symbol result carries a zero value.
    `NBSC_NEVER(a_bad_zero,
        m_axis_tvalid && m_axis_tuser && (m_axis_tdata != 16'h0000),
        "bad symbol result with nonzero value")

    // Values between the Latin-1 block and the punctuation block lie in the Greek range only.
    `NBSC_NEVER(a_gap,
        m_axis_tvalid && (m_axis_tdata >= 16'h0180) && (m_axis_tdata < 16'h2010)
            && ((m_axis_tdata < 16'h0391) || (m_axis_tdata > 16'h03B1)),
        "result outside every code range")

    // A configuration write does not change the value of a waiting result.
    `NBSC_ASSERT(a_cfg_quiet,
        i_cfg_we && m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata),
        "result moved under a region write")

endmodule

bind nine_bit_symbol_codec nbsc_checker u_nbsc_checker (.*);
